FILE: rtl/tmst_pkg.sv
// Shared types, codes and default sizes for the Turing machine stepper.
// Depends on nothing; the head move unit, the stepper and the checker refer to it by scope.
package tmst_pkg;

   localparam int NUM_STATES_DEF = 128;
   localparam int MAX_OPS_DEF    = 8;
   localparam int TAPE_LEN_DEF   = 1024;
   localparam int NUM_SYMS       = 256;

   localparam logic [9:0] HEAD_START_RST = 10'd512;

   localparam logic [7:0] BLANK_SYM    = 8'd32;
   localparam logic [7:0] FALLBACK_SYM = 8'd63;

   // Request opcodes.
   localparam logic [2:0] OPC_CLEAR    = 3'd0;
   localparam logic [2:0] OPC_LOAD_OP  = 3'd1;
   localparam logic [2:0] OPC_LOAD_HDR = 3'd2;
   localparam logic [2:0] OPC_STEP     = 3'd3;
   localparam logic [2:0] OPC_READ     = 3'd4;

   // Operation kinds held in the operation store.
   localparam logic [2:0] KIND_LEFT  = 3'd0;
   localparam logic [2:0] KIND_RIGHT = 3'd1;
   localparam logic [2:0] KIND_ERASE = 3'd2;
   localparam logic [2:0] KIND_PRINT = 3'd3;

   // Response status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_ENTRY = 3'd1;
   localparam logic [2:0] ST_UNKNOWN  = 3'd2;
   localparam logic [2:0] ST_BAD_OP   = 3'd3;
   localparam logic [2:0] ST_EDGE     = 3'd4;

   // Outcome of the head move unit.
   typedef struct packed {
      logic is_move;
      logic edge_hit;
   } move_res_type;

endpackage

FILE: rtl/tmst_req_if.sv
// Request channel of the Turing machine stepper: valid, ready and payload.
// Depends on nothing.
interface tmst_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [6:0] state_index;
   logic [7:0] symbol;
   logic [2:0] op_slot;
   logic [2:0] op_kind;
   logic [7:0] op_char;
   logic [3:0] op_count;
   logic [6:0] next_state;
   logic       next_known;
   logic [9:0] tape_addr;

   modport source (output valid, opcode, state_index, symbol, op_slot, op_kind, op_char,
                   op_count, next_state, next_known, tape_addr, input ready);
   modport sink (input valid, opcode, state_index, symbol, op_slot, op_kind, op_char,
                 op_count, next_state, next_known, tape_addr, output ready);
endinterface

FILE: rtl/tmst_rsp_if.sv
// Response channel of the Turing machine stepper: valid, ready and payload.
// Depends on nothing.
interface tmst_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [6:0] current_state;
   logic [9:0] head_pos;
   logic [7:0] head_symbol;
   logic [7:0] cell_symbol;

   modport source (output valid, status, current_state, head_pos, head_symbol, cell_symbol,
                   input ready);
   modport sink (input valid, status, current_state, head_pos, head_symbol, cell_symbol,
                 output ready);
endinterface

FILE: rtl/tmst_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module tmst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tmst_head_alu.sv
// Head move unit: steps the head one cell left or right and flags the tape edges.
// Depends on tmst_pkg.
module tmst_head_alu #(
   parameter int TAPE_LEN = tmst_pkg::TAPE_LEN_DEF
) (
   input  logic [$clog2(TAPE_LEN)-1:0] head,
   input  logic [2:0]                  kind,
   output logic [$clog2(TAPE_LEN)-1:0] head_next,
   output tmst_pkg::move_res_type      res
);

   localparam int TAW = $clog2(TAPE_LEN);
   localparam logic [TAW-1:0] LAST_CELL = TAW'(TAPE_LEN - 1);

   always_comb begin
      head_next    = head;
      res.is_move  = 1'b0;
      res.edge_hit = 1'b0;
      case (kind)
         tmst_pkg::KIND_LEFT: begin
            res.is_move  = 1'b1;
            res.edge_hit = (head == '0);
            if (head != '0) begin
               head_next = head - 1'b1;
            end
         end
         tmst_pkg::KIND_RIGHT: begin
            res.is_move  = 1'b1;
            res.edge_hit = (head == LAST_CELL);
            if (head != LAST_CELL) begin
               head_next = head + 1'b1;
            end
         end
         default: begin
            head_next = head;
         end
      endcase
   end

endmodule

FILE: rtl/turing_machine_stepper.sv
// A load or unused opcode passes dispatch, finish and push; a read adds a cell fetch; a step
// adds header fetch, header check (twice for the fallback entry) and each operation run.
// Throughput: one transaction at a time; the operation loop runs one operation per cycle.
// Reset and clear start a blanking pass over the table and tape RAMs; no request is taken
// until it ends.
module turing_machine_stepper #(
   parameter int NUM_STATES = tmst_pkg::NUM_STATES_DEF,
   parameter int MAX_OPS    = tmst_pkg::MAX_OPS_DEF,
   parameter int TAPE_LEN   = tmst_pkg::TAPE_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   tmst_req_if.sink         req_chan,
   tmst_rsp_if.source       rsp_chan,
   input  logic             csr_we,
   input  logic [9:0]       csr_wdata
);

   // Address widths. The operation slot field is at least one bit wide so the
   // operation store address always exists, even with a single slot.
   localparam int SW      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int OW      = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
   localparam int CW      = $clog2(MAX_OPS + 1);
   localparam int TAW     = $clog2(TAPE_LEN);
   localparam int EAW     = SW + 8;
   localparam int OAW     = EAW + OW;
   localparam int ENTRIES = NUM_STATES * tmst_pkg::NUM_SYMS;
   localparam int OP_DEPTH = ENTRIES * (2 ** OW);
   localparam int SWEEP_N = (ENTRIES > TAPE_LEN) ? ENTRIES : TAPE_LEN;
   localparam int SCW     = $clog2(SWEEP_N);

   // Header word: valid, next known, next state, operation count.
   localparam int HW      = CW + 9;
   localparam int H_VALID = HW - 1;
   localparam int H_KNOWN = HW - 2;
   localparam int H_NXT_HI = HW - 3;
   localparam int H_NXT_LO = CW;

   localparam logic [TAW-1:0] RESET_HEAD =
      (int'(tmst_pkg::HEAD_START_RST) >= TAPE_LEN) ? TAW'(TAPE_LEN - 1)
                                                   : TAW'(tmst_pkg::HEAD_START_RST);

   typedef enum logic [3:0] {
      S_SWEEP, S_IDLE, S_DISP, S_CELL, S_HDR, S_HCHK, S_HCHK2, S_OP, S_FIN, S_PUSH
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // Control state.
   logic [SCW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic           sweep_rsp_ff, sweep_rsp_in;
   logic           out_valid_ff, out_valid_in;
   logic [6:0]     mstate_ff, mstate_in;
   logic [TAW-1:0] head_ff, head_in;
   logic [9:0]     csr_ff, csr_in;

   // Captured request fields.
   logic [2:0] opc_ff, opc_in;
   logic [6:0] sidx_ff, sidx_in;
   logic [7:0] sym_ff, sym_in;
   logic [2:0] slot_ff, slot_in;
   logic [2:0] kind_ff, kind_in;
   logic [7:0] char_ff, char_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [6:0] nxt_ff, nxt_in;
   logic       known_ff, known_in;
   logic [9:0] addr_ff, addr_in;

   // Step working registers.
   logic [EAW-1:0] ent_ff, ent_in;
   logic [6:0]     nxts_ff, nxts_in;
   logic [CW-1:0]  opn_ff, opn_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [2:0]     status_ff, status_in;
   logic [7:0]     cell_ff, cell_in;

   // Response payload registers.
   logic [2:0] o_status_ff, o_status_in;
   logic [6:0] o_state_ff, o_state_in;
   logic [9:0] o_head_ff, o_head_in;
   logic [7:0] o_hsym_ff, o_hsym_in;
   logic [7:0] o_cell_ff, o_cell_in;

   // RAM ports.
   logic           tape_we, tape_re;
   logic [TAW-1:0] tape_waddr, tape_raddr;
   logic [7:0]     tape_wdata, tape_rdata;
   logic           hdr_we, hdr_re;
   logic [EAW-1:0] hdr_waddr, hdr_raddr;
   logic [HW-1:0]  hdr_wdata, hdr_rdata;
   logic           op_we, op_re;
   logic [OAW-1:0] op_waddr, op_raddr;
   logic [10:0]    op_wdata, op_rdata;

   // Head move unit, used by the operation loop.
   logic [TAW-1:0]         alu_head;
   tmst_pkg::move_res_type alu_res;

   logic [CW-1:0]  cnt_clamp;
   logic [CW-1:0]  idx_nx;
   logic [TAW-1:0] start_cell;
   logic [6:0]     hdr_nxt;

   tmst_ram #(.WIDTH(8), .DEPTH(TAPE_LEN)) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata),
      .rd_en   (tape_re),
      .rd_addr (tape_raddr),
      .rd_data (tape_rdata)
   );

   tmst_ram #(.WIDTH(HW), .DEPTH(ENTRIES)) u_hdr (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (hdr_waddr),
      .wr_data (hdr_wdata),
      .rd_en   (hdr_re),
      .rd_addr (hdr_raddr),
      .rd_data (hdr_rdata)
   );

   tmst_ram #(.WIDTH(11), .DEPTH(OP_DEPTH)) u_ops (
      .clock   (clock),
      .wr_en   (op_we),
      .wr_addr (op_waddr),
      .wr_data (op_wdata),
      .rd_en   (op_re),
      .rd_addr (op_raddr),
      .rd_data (op_rdata)
   );

   tmst_head_alu #(.TAPE_LEN(TAPE_LEN)) u_alu (
      .head      (head_ff),
      .kind      (op_rdata[10:8]),
      .head_next (alu_head),
      .res       (alu_res)
   );

   // An operation count above the slot count is clamped when the header is loaded.
   assign cnt_clamp = (int'(cnt_ff) > MAX_OPS) ? CW'(MAX_OPS) : CW'(cnt_ff);
   assign idx_nx    = idx_ff + 1'b1;
   // A start cell beyond the tape places the head on the last cell.
   assign start_cell = (int'(csr_ff) >= TAPE_LEN) ? TAW'(TAPE_LEN - 1) : TAW'(csr_ff);
   assign hdr_nxt   = hdr_rdata[H_NXT_HI:H_NXT_LO];

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      sweep_rsp_in = sweep_rsp_ff;
      out_valid_in = out_valid_ff;
      mstate_in    = mstate_ff;
      head_in      = head_ff;
      csr_in       = csr_ff;
      opc_in       = opc_ff;
      sidx_in      = sidx_ff;
      sym_in       = sym_ff;
      slot_in      = slot_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      cnt_in       = cnt_ff;
      nxt_in       = nxt_ff;
      known_in     = known_ff;
      addr_in      = addr_ff;
      ent_in       = ent_ff;
      nxts_in      = nxts_ff;
      opn_in       = opn_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      cell_in      = cell_ff;
      o_status_in  = o_status_ff;
      o_state_in   = o_state_ff;
      o_head_in    = o_head_ff;
      o_hsym_in    = o_hsym_ff;
      o_cell_in    = o_cell_ff;

      tape_we    = 1'b0;
      tape_waddr = head_ff;
      tape_wdata = tmst_pkg::BLANK_SYM;
      tape_re    = 1'b0;
      tape_raddr = head_ff;
      hdr_we     = 1'b0;
      hdr_waddr  = {SW'(sidx_ff), sym_ff};
      hdr_wdata  = {1'b1, known_ff, nxt_ff, cnt_clamp};
      hdr_re     = 1'b0;
      hdr_raddr  = {SW'(mstate_ff), tape_rdata};
      op_we      = 1'b0;
      op_waddr   = {SW'(sidx_ff), sym_ff, OW'(slot_ff)};
      op_wdata   = {kind_ff, char_ff};
      op_re      = 1'b0;
      op_raddr   = {ent_ff, OW'(idx_nx)};

      // The register takes effect at the next clear; reset restores its default.
      if (csr_we) begin
         csr_in = csr_wdata;
      end

      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_SWEEP: begin
            // One table entry and one tape cell are blanked per cycle.
            hdr_we     = (int'(sweep_cnt_ff) < ENTRIES);
            hdr_waddr  = EAW'(sweep_cnt_ff);
            hdr_wdata  = '0;
            tape_we    = (int'(sweep_cnt_ff) < TAPE_LEN);
            tape_waddr = TAW'(sweep_cnt_ff);
            tape_wdata = tmst_pkg::BLANK_SYM;
            if (sweep_cnt_ff == SCW'(SWEEP_N - 1)) begin
               state_in = sweep_rsp_ff ? S_FIN : S_IDLE;
            end else begin
               sweep_cnt_in = sweep_cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               opc_in   = req_chan.opcode;
               sidx_in  = req_chan.state_index;
               sym_in   = req_chan.symbol;
               slot_in  = req_chan.op_slot;
               kind_in  = req_chan.op_kind;
               char_in  = req_chan.op_char;
               cnt_in   = req_chan.op_count;
               nxt_in   = req_chan.next_state;
               known_in = req_chan.next_known;
               addr_in  = req_chan.tape_addr;
               cell_in  = '0;
               status_in = tmst_pkg::ST_OK;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_FIN;
            case (opc_ff)
               tmst_pkg::OPC_CLEAR: begin
                  mstate_in    = '0;
                  head_in      = start_cell;
                  sweep_cnt_in = '0;
                  sweep_rsp_in = 1'b1;
                  state_in     = S_SWEEP;
               end
               tmst_pkg::OPC_LOAD_OP: begin
                  op_we = (int'(sidx_ff) < NUM_STATES) && (int'(slot_ff) < MAX_OPS);
               end
               tmst_pkg::OPC_LOAD_HDR: begin
                  hdr_we = (int'(sidx_ff) < NUM_STATES);
               end
               tmst_pkg::OPC_STEP: begin
                  tape_re  = 1'b1;
                  state_in = S_HDR;
               end
               tmst_pkg::OPC_READ: begin
                  tape_re    = (int'(addr_ff) < TAPE_LEN);
                  tape_raddr = TAW'(addr_ff);
                  state_in   = S_CELL;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_CELL: begin
            cell_in  = (int'(addr_ff) < TAPE_LEN) ? tape_rdata : tmst_pkg::BLANK_SYM;
            state_in = S_FIN;
         end
         S_HDR: begin
            // The scanned symbol is now in the tape read register.
            ent_in    = {SW'(mstate_ff), tape_rdata};
            hdr_re    = 1'b1;
            hdr_raddr = {SW'(mstate_ff), tape_rdata};
            state_in  = S_HCHK;
         end
         S_HCHK, S_HCHK2: begin
            if (!hdr_rdata[H_VALID]) begin
               if (state_ff == S_HCHK) begin
                  // No entry for the scanned symbol: try the fallback entry.
                  ent_in    = {SW'(mstate_ff), tmst_pkg::FALLBACK_SYM};
                  hdr_re    = 1'b1;
                  hdr_raddr = {SW'(mstate_ff), tmst_pkg::FALLBACK_SYM};
                  state_in  = S_HCHK2;
               end else begin
                  status_in = tmst_pkg::ST_NO_ENTRY;
                  state_in  = S_FIN;
               end
            end else if (!hdr_rdata[H_KNOWN] || (int'(hdr_nxt) >= NUM_STATES)) begin
               status_in = tmst_pkg::ST_UNKNOWN;
               state_in  = S_FIN;
            end else begin
               nxts_in = hdr_nxt;
               opn_in  = hdr_rdata[CW-1:0];
               idx_in  = '0;
               if (hdr_rdata[CW-1:0] == '0) begin
                  mstate_in = hdr_nxt;
                  state_in  = S_FIN;
               end else begin
                  op_re    = 1'b1;
                  op_raddr = {ent_ff, OW'(0)};
                  state_in = S_OP;
               end
            end
         end
         S_OP: begin
            // Operation idx_ff is in the read register; the next one is fetched now.
            if (alu_res.is_move && alu_res.edge_hit) begin
               status_in = tmst_pkg::ST_EDGE;
               state_in  = S_FIN;
            end else if (op_rdata[10:8] > tmst_pkg::KIND_PRINT) begin
               status_in = tmst_pkg::ST_BAD_OP;
               state_in  = S_FIN;
            end else begin
               head_in    = alu_head;
               tape_we    = (op_rdata[10:8] == tmst_pkg::KIND_ERASE) ||
                            (op_rdata[10:8] == tmst_pkg::KIND_PRINT);
               tape_wdata = (op_rdata[10:8] == tmst_pkg::KIND_PRINT) ? op_rdata[7:0]
                                                                     : tmst_pkg::BLANK_SYM;
               if (idx_nx == opn_ff) begin
                  mstate_in = nxts_ff;
                  state_in  = S_FIN;
               end else begin
                  idx_in = idx_nx;
                  op_re  = 1'b1;
               end
            end
         end
         S_FIN: begin
            tape_re  = 1'b1;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            // The symbol under the head is held in the tape read register.
            if (!out_valid_ff || rsp_chan.ready) begin
               o_status_in  = status_ff;
               o_state_in   = mstate_ff;
               o_head_in    = 10'(head_ff);
               o_hsym_in    = tape_rdata;
               o_cell_in    = cell_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_cnt_ff <= '0;
         sweep_rsp_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         mstate_ff    <= '0;
         head_ff      <= RESET_HEAD;
         csr_ff       <= tmst_pkg::HEAD_START_RST;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         sweep_rsp_ff <= sweep_rsp_in;
         out_valid_ff <= out_valid_in;
         mstate_ff    <= mstate_in;
         head_ff      <= head_in;
         csr_ff       <= csr_in;
      end
      opc_ff      <= opc_in;
      sidx_ff     <= sidx_in;
      sym_ff      <= sym_in;
      slot_ff     <= slot_in;
      kind_ff     <= kind_in;
      char_ff     <= char_in;
      cnt_ff      <= cnt_in;
      nxt_ff      <= nxt_in;
      known_ff    <= known_in;
      addr_ff     <= addr_in;
      ent_ff      <= ent_in;
      nxts_ff     <= nxts_in;
      opn_ff      <= opn_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      cell_ff     <= cell_in;
      o_status_ff <= o_status_in;
      o_state_ff  <= o_state_in;
      o_head_ff   <= o_head_in;
      o_hsym_ff   <= o_hsym_in;
      o_cell_ff   <= o_cell_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = o_status_ff;
   assign rsp_chan.current_state = o_state_ff;
   assign rsp_chan.head_pos      = o_head_ff;
   assign rsp_chan.head_symbol   = o_hsym_ff;
   assign rsp_chan.cell_symbol   = o_cell_ff;

endmodule

FILE: rtl/tmst_checker.sv
// Port-level checks of the Turing machine stepper and the bind that attaches them.
// Depends on tmst_pkg and on the top level turing_machine_stepper.
module tmst_checker #(
   parameter int TAPE_LEN = tmst_pkg::TAPE_LEN_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [9:0] rsp_head_pos
);

   // Reset starts the blanking pass, so no request is taken right after it.
   a_reset_busy: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken right after reset");

   // Requests are handled one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while one is in work");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= tmst_pkg::ST_EDGE))
      else $error("status code out of range");

   // An edge halt leaves the head on the first or last cell.
   a_edge_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == tmst_pkg::ST_EDGE)) |->
      ((rsp_head_pos == 10'd0) || (rsp_head_pos == 10'(TAPE_LEN - 1))))
      else $error("edge status with head away from the tape ends");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind turing_machine_stepper tmst_checker #(.TAPE_LEN(TAPE_LEN)) u_tmst_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_status   (rsp_chan.status),
   .rsp_head_pos (rsp_chan.head_pos)
);
